/* src/odm_pkg.sv */
package odm_pkg;

    localparam int POS_WIDTH_DEF   = 24;
    localparam int SPEED_WIDTH_DEF = 16;
    localparam int WINDOW_DEG_DEF  = 5;

    localparam int FULL_TURN  = 360;
    localparam int HEAD_W     = 9;
    localparam int TDIST_W    = 24;
    localparam int TSQ_W      = 2 * TDIST_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DIST   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABSOLUTE_MODE = 8'd3;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_STRAIGHT = 2'd1,
        PH_ROTATE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic has_result;
        logic finished;
    } step_flags_t;

    function automatic logic [HEAD_W-1:0] wrap_heading(input logic [HEAD_W-1:0] h);
        logic [HEAD_W-1:0] turn;
        turn = HEAD_W'(FULL_TURN);
        return (h >= turn) ? h - turn : h;
    endfunction

endpackage

/* src/odometry_move_sequencer_core.sv */
// Odometry move sequencer.
// Moves are configured through the cfg write channel (speed, target distance,
// target angle, absolute mode); the user must write them only while no move is
// running, as the block itself does not enforce this. On the s_ channel an item
// with tuser low starts a move; an item with tuser high is an odometry sample.
// While a move runs, each sample produces one transfer on the m_ channel
// carrying linear and angular speed; tlast marks the sample that ended the
// move, which carries zero speeds and leaves the block idle. Start items and
// samples taken while idle produce no transfer. An item waits in the input
// register and its result is then registered in the output register, which
// drives m_tvalid. One item is accepted per cycle when the receiver keeps up;
// the squares, compares and heading arithmetic all fit in the single stage
// between the two registers.
// When the receiver stalls, the result waits in the output register and the
// input register takes one more item; once that item needs the output register,
// s_tready drops until the result is taken. Reset clears the configuration,
// leaves the block idle and empties both registers.
module odometry_move_sequencer_core #(
    parameter int POS_WIDTH   = odm_pkg::POS_WIDTH_DEF,
    parameter int SPEED_WIDTH = odm_pkg::SPEED_WIDTH_DEF,
    parameter int WINDOW_DEG  = odm_pkg::WINDOW_DEG_DEF,
    localparam int IN_DATA_W  = ((2 * POS_WIDTH + odm_pkg::HEAD_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * SPEED_WIDTH + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [odm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [odm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_DATA_W-1:0]            s_tdata,   // pos_x, pos_y, heading_deg, zero fill
    input  logic                            s_tuser,   // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_DATA_W-1:0]           m_tdata,   // linear_speed, angular_speed, zero fill
    output logic                            m_tlast    // move_finished
);

    localparam int P = POS_WIDTH;
    localparam int S = SPEED_WIDTH;

    logic                          in_valid_reg, in_valid_next;
    logic                          in_kind_reg;
    logic signed [P-1:0]           in_x_reg, in_y_reg;
    logic [odm_pkg::HEAD_W-1:0]    in_h_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [S-1:0]           out_lin_reg, out_ang_reg;
    logic                          out_fin_reg;

    logic signed [S-1:0]           speed;
    logic [odm_pkg::TSQ_W-1:0]     target_dist_sq;
    logic [odm_pkg::HEAD_W-1:0]    target_angle;
    logic                          absolute_mode;
    odm_pkg::step_flags_t          flags;
    logic signed [S-1:0]           lin, ang;
    logic                          s_accept, out_free, fire, load_out;

    assign cfg_ready = 1'b1;

    odm_cfg_regs #(
        .SPEED_WIDTH(S)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .speed          (speed),
        .target_dist_sq (target_dist_sq),
        .target_angle   (target_angle),
        .absolute_mode  (absolute_mode)
    );

    odm_move_ctrl #(
        .POS_WIDTH   (P),
        .SPEED_WIDTH (S),
        .WINDOW_DEG  (WINDOW_DEG)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .kind           (in_kind_reg),
        .pos_x          (in_x_reg),
        .pos_y          (in_y_reg),
        .heading_deg    (in_h_reg),
        .speed          (speed),
        .target_dist_sq (target_dist_sq),
        .target_angle   (target_angle),
        .absolute_mode  (absolute_mode),
        .flags          (flags),
        .linear_speed   (lin),
        .angular_speed  (ang)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!flags.has_result || out_free);
    assign load_out = fire && flags.has_result;
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_kind_reg <= s_tuser;
            in_x_reg    <= s_tdata[P-1:0];
            in_y_reg    <= s_tdata[2*P-1:P];
            in_h_reg    <= s_tdata[2*P+odm_pkg::HEAD_W-1:2*P];
        end
        if (load_out)
        begin
            out_lin_reg <= lin;
            out_ang_reg <= ang;
            out_fin_reg <= flags.finished;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_ang_reg, out_lin_reg});
    assign m_tlast  = out_fin_reg;

`ifndef SYNTHESIS
    // A finishing result always carries zero speeds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata == '0))
        else $error("finishing result carries a nonzero speed");

    // Linear and angular commands are never issued together.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_lin_reg == '0) || (out_ang_reg == '0)))
        else $error("linear and angular speed both nonzero");

    // Start items never wait on the output side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (in_kind_reg == odm_pkg::KIND_START)) |-> fire)
        else $error("start item stalled");
`endif

endmodule

/* src/odm_cfg_regs.sv */
module odm_cfg_regs #(
    parameter int SPEED_WIDTH = odm_pkg::SPEED_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [odm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [odm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic signed [SPEED_WIDTH-1:0]    speed,
    output logic [odm_pkg::TSQ_W-1:0]        target_dist_sq,
    output logic [odm_pkg::HEAD_W-1:0]       target_angle,
    output logic                             absolute_mode
);

    logic signed [SPEED_WIDTH-1:0]  speed_reg, speed_next;
    logic [odm_pkg::TSQ_W-1:0]      tsq_reg, tsq_next;
    logic [odm_pkg::HEAD_W-1:0]     angle_reg, angle_next;
    logic                           abs_reg, abs_next;
    logic [odm_pkg::TDIST_W-1:0]    tdist_wr;

    assign tdist_wr = cfg_data[odm_pkg::TDIST_W-1:0];

    // The squared distance is formed once per write, so no sample needs a third square.
    always_comb
    begin
        speed_next = speed_reg;
        tsq_next   = tsq_reg;
        angle_next = angle_reg;
        abs_next   = abs_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                odm_pkg::REG_SPEED:         speed_next = cfg_data[SPEED_WIDTH-1:0];
                odm_pkg::REG_TARGET_DIST:   tsq_next = odm_pkg::TSQ_W'(tdist_wr)
                                                     * odm_pkg::TSQ_W'(tdist_wr);
                odm_pkg::REG_TARGET_ANGLE:  angle_next = cfg_data[odm_pkg::HEAD_W-1:0];
                odm_pkg::REG_ABSOLUTE_MODE: abs_next = cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
            tsq_reg   <= '0;
            angle_reg <= '0;
            abs_reg   <= 1'b0;
        end
        else
        begin
            speed_reg <= speed_next;
            tsq_reg   <= tsq_next;
            angle_reg <= angle_next;
            abs_reg   <= abs_next;
        end
    end

    assign speed          = speed_reg;
    assign target_dist_sq = tsq_reg;
    assign target_angle   = angle_reg;
    assign absolute_mode  = abs_reg;

endmodule

/* src/odm_move_ctrl.sv */
module odm_move_ctrl #(
    parameter int POS_WIDTH   = odm_pkg::POS_WIDTH_DEF,
    parameter int SPEED_WIDTH = odm_pkg::SPEED_WIDTH_DEF,
    parameter int WINDOW_DEG  = odm_pkg::WINDOW_DEG_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic                           kind,
    input  logic signed [POS_WIDTH-1:0]    pos_x,
    input  logic signed [POS_WIDTH-1:0]    pos_y,
    input  logic [odm_pkg::HEAD_W-1:0]     heading_deg,
    input  logic signed [SPEED_WIDTH-1:0]  speed,
    input  logic [odm_pkg::TSQ_W-1:0]      target_dist_sq,
    input  logic [odm_pkg::HEAD_W-1:0]     target_angle,
    input  logic                           absolute_mode,
    output odm_pkg::step_flags_t           flags,
    output logic signed [SPEED_WIDTH-1:0]  linear_speed,
    output logic signed [SPEED_WIDTH-1:0]  angular_speed
);

    localparam int DIFF_W = POS_WIDTH + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int CMP_W  = (SUM_W > odm_pkg::TSQ_W) ? SUM_W : odm_pkg::TSQ_W;
    localparam int HW     = odm_pkg::HEAD_W;
    localparam int AW     = HW + 1;
    localparam logic [AW-1:0] TURN_A    = AW'(odm_pkg::FULL_TURN);
    localparam logic [AW-1:0] WIN_A     = AW'(WINDOW_DEG);
    localparam logic [AW-1:0] TURN_LESS = AW'(odm_pkg::FULL_TURN - WINDOW_DEG);

    odm_pkg::phase_t              phase_reg, phase_next;
    logic                         captured_reg, captured_next;
    logic signed [POS_WIDTH-1:0]  start_x_reg, start_y_reg;
    logic [HW-1:0]                start_h_reg;

    logic                         active;
    logic [HW-1:0]                cur_h, eff_h;
    logic signed [POS_WIDTH-1:0]  eff_x, eff_y;
    logic signed [DIFF_W-1:0]     dx_s, dy_s;
    logic [DIFF_W-1:0]            mag_x, mag_y;
    logic [SQ_W-1:0]              sq_x, sq_y;
    logic [SUM_W-1:0]             dist_sq;
    logic                         in_reach;
    logic [AW-1:0]                d_raw, d_wrap, a_ext, cur_ext, hi, lo;
    logic                         rel_done, abs_done, rot_done;

    assign active = (phase_reg == odm_pkg::PH_STRAIGHT) || (phase_reg == odm_pkg::PH_ROTATE);

    // The first sample of a move is its own start pose.
    assign cur_h = odm_pkg::wrap_heading(heading_deg);
    assign eff_x = captured_reg ? start_x_reg : pos_x;
    assign eff_y = captured_reg ? start_y_reg : pos_y;
    assign eff_h = captured_reg ? start_h_reg : cur_h;

    assign dx_s  = DIFF_W'(pos_x) - DIFF_W'(eff_x);
    assign dy_s  = DIFF_W'(pos_y) - DIFF_W'(eff_y);
    assign mag_x = dx_s[DIFF_W-1] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
    assign mag_y = dy_s[DIFF_W-1] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);
    assign sq_x  = SQ_W'(mag_x) * SQ_W'(mag_x);
    assign sq_y  = SQ_W'(mag_y) * SQ_W'(mag_y);
    assign dist_sq  = SUM_W'(sq_x) + SUM_W'(sq_y);
    assign in_reach = CMP_W'(dist_sq) < CMP_W'(target_dist_sq);

    assign cur_ext  = AW'(cur_h);
    assign a_ext    = AW'(target_angle);
    assign d_raw    = cur_ext - AW'(eff_h);
    assign d_wrap   = d_raw[AW-1] ? d_raw + TURN_A : d_raw;
    assign rel_done = d_wrap >= a_ext;

    assign hi = (a_ext >= TURN_LESS) ? a_ext - TURN_LESS : a_ext + WIN_A;
    assign lo = (a_ext <= WIN_A) ? a_ext + TURN_LESS : a_ext - WIN_A;
    assign abs_done = (hi > lo) ? ((cur_ext > lo) && (cur_ext < hi))
                                : ((cur_ext > lo) || (cur_ext < hi));
    assign rot_done = absolute_mode ? abs_done : rel_done;

    always_comb
    begin
        phase_next    = phase_reg;
        captured_next = captured_reg;
        if (fire)
        begin
            if (kind == odm_pkg::KIND_START)
            begin
                phase_next = (target_angle != '0) ? odm_pkg::PH_ROTATE : odm_pkg::PH_STRAIGHT;
            end
            else if (active)
            begin
                captured_next = !flags.finished;
                if (flags.finished)
                begin
                    phase_next = odm_pkg::PH_IDLE;
                end
            end
        end
    end

    always_comb
    begin
        flags.has_result = (kind == odm_pkg::KIND_SAMPLE) && active;
        flags.finished   = 1'b0;
        linear_speed     = '0;
        angular_speed    = '0;
        unique case (phase_reg)
            odm_pkg::PH_STRAIGHT:
            begin
                flags.finished = flags.has_result && !in_reach;
                linear_speed   = in_reach ? speed : '0;
            end
            odm_pkg::PH_ROTATE:
            begin
                flags.finished = flags.has_result && rot_done;
                angular_speed  = rot_done ? '0 : speed;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= odm_pkg::PH_IDLE;
            captured_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            captured_reg <= captured_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && flags.has_result && !captured_reg)
        begin
            start_x_reg <= pos_x;
            start_y_reg <= pos_y;
            start_h_reg <= cur_h;
        end
    end

endmodule
